// ===== design/aoac_pkg.sv =====
// shared types, constants and helper functions for the overlay compositor
`default_nettype none
package aoac_pkg;

    localparam int DEF_OVERLAY_DEPTH = 4096;
    localparam int DEF_MAX_DIMENSION = 4096;

    // signed width for placement math
    localparam int PW = 18;
    localparam int QUEUE_DEPTH = 4;
    localparam int ALPHA_FULL = 65025;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAY_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAY_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OPACITY        = 3'd6;

    localparam logic [1:0] SEL_NEAR   = 2'd0;
    localparam logic [1:0] SEL_CENTER = 2'd1;
    localparam logic [1:0] SEL_FAR    = 2'd2;

    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_COMPOSITE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [11:0] load_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       frame_end;
    } t_out_word;

    typedef struct packed {
        logic [12:0] base_width;
        logic [12:0] base_height;
        logic [6:0]  overlay_width;
        logic [6:0]  overlay_height;
        logic [3:0]  anchor_position;
        logic [11:0] edge_margin;
    } t_place_cfg;

    // one classified base pixel; words are r | g<<8 | b<<16 | a<<24
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] ovl;
        logic        covered;
        logic        frame_end;
    } t_job;

    function automatic logic [1:0] anchor_col(input logic [3:0] a);
        logic [1:0] c;
        case (a)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: c = SEL_NEAR;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       c = SEL_CENTER;
            default:                              c = SEL_FAR;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] anchor_row(input logic [3:0] a);
        logic [1:0] r;
        if (a < 4'd3) begin
            r = SEL_NEAR;
        end else if (a < 4'd6) begin
            r = SEL_CENTER;
        end else begin
            r = SEL_FAR;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/aoac_pix_if.sv =====
// input channel: valid/ready handshake carrying one pixel command word
`default_nettype none
interface aoac_pix_if;
    logic              valid;
    logic              ready;
    aoac_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/aoac_res_if.sv =====
// output channel: valid/ready handshake carrying one composited pixel word
`default_nettype none
interface aoac_res_if;
    logic               valid;
    logic               ready;
    aoac_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/aoac_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module aoac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== design/aoac_front.sv =====
// front end: accepts words, loads the overlay store, places and classifies base pixels
`default_nettype none
module aoac_front #(
    parameter int OVERLAY_DEPTH = aoac_pkg::DEF_OVERLAY_DEPTH,
    parameter int MAX_DIMENSION = aoac_pkg::DEF_MAX_DIMENSION
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire aoac_pkg::t_place_cfg i_cfg,
    aoac_pix_if.sink                  i_pix,
    output      logic                 o_push,
    output      aoac_pkg::t_job       o_job,
    input  wire logic                 i_full
);
    localparam int PW = aoac_pkg::PW;
    localparam int AW = $clog2(OVERLAY_DEPTH);
    localparam int CW = $clog2(MAX_DIMENSION);

    logic [CW-1:0] r_col, n_col, r_row, n_row;
    logic          r_s1_v, n_s1_v;
    logic [31:0]   r_s1_base;
    logic          r_s1_cov, r_s1_fe;

    logic accept, ld, cp;
    logic signed [PW-1:0] w, h, ow, oh, mg, px, py, x, y, i, j, dx, dy;
    logic [1:0]  sel_c, sel_r;
    logic [13:0] addr;
    logic        cov, addr_ok, ld_ok, last_col, last_row;
    logic [16:0] ld_wide, rd_wide;
    logic [31:0] pix_word, rdata;

    function automatic logic signed [PW-1:0] clamp_dim(input logic [12:0] v);
        logic [PW-1:0] wv;
        wv = PW'(v);
        if (wv == '0) begin
            wv = PW'(1);
        end else if (wv > PW'(MAX_DIMENSION)) begin
            wv = PW'(MAX_DIMENSION);
        end
        return signed'(wv);
    endfunction

    function automatic logic signed [PW-1:0] place(input logic [1:0] sel,
            input logic signed [PW-1:0] full, input logic signed [PW-1:0] part,
            input logic signed [PW-1:0] m);
        logic signed [PW-1:0] d, r;
        d = full - part;
        case (sel)
            aoac_pkg::SEL_NEAR:   r = m;
            // halve with truncation toward zero
            aoac_pkg::SEL_CENTER: r = (d + signed'(PW'(d[PW-1]))) >>> 1;
            default:              r = d - m;
        endcase
        return r;
    endfunction

    assign accept = i_pix.valid && i_pix.ready;
    assign ld = accept && (i_pix.data.cmd == aoac_pkg::CMD_LOAD);
    assign cp = accept && (i_pix.data.cmd == aoac_pkg::CMD_COMPOSITE);
    assign o_push = r_s1_v && !i_full;
    assign i_pix.ready = !r_s1_v || !i_full;

    always_comb begin
        w = clamp_dim(i_cfg.base_width);
        h = clamp_dim(i_cfg.base_height);
        ow = signed'(PW'(i_cfg.overlay_width));
        oh = signed'(PW'(i_cfg.overlay_height));
        mg = signed'(PW'(i_cfg.edge_margin));
        sel_c = aoac_pkg::anchor_col(i_cfg.anchor_position);
        sel_r = aoac_pkg::anchor_row(i_cfg.anchor_position);
        px = place(sel_c, w, ow, mg);
        py = place(sel_r, h, oh, mg);
        x = signed'(PW'(r_col));
        y = signed'(PW'(r_row));
        i = x - px;
        j = y - py;
        dx = w - signed'(PW'(1));
        dy = h - signed'(PW'(1));
        cov = (ow != '0) && (oh != '0) && (i >= 0) && (i < ow) && (j >= 0) && (j < oh)
              && (x < w) && (y < h);
        addr = 14'(j[6:0]) * 14'(i_cfg.overlay_width) + 14'(i[6:0]);
        rd_wide = 17'(addr);
        addr_ok = rd_wide < 17'(OVERLAY_DEPTH);
        ld_wide = 17'(i_pix.data.load_index);
        ld_ok = ld_wide < 17'(OVERLAY_DEPTH);
        last_col = x >= dx;
        last_row = y >= dy;
        pix_word = {i_pix.data.alpha, i_pix.data.blue, i_pix.data.green, i_pix.data.red};
    end

    aoac_ram #(.WIDTH(32), .DEPTH(OVERLAY_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ld && ld_ok),
        .i_waddr (ld_wide[AW-1:0]),
        .i_wdata (pix_word),
        .i_re    (cp && cov && addr_ok),
        .i_raddr (rd_wide[AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_s1_v = r_s1_v;
        if (o_push) begin
            n_s1_v = 1'b0;
        end
        if (cp) begin
            n_s1_v = 1'b1;
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : CW'(r_row + 1'b1);
            end else begin
                n_col = CW'(r_col + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1_v <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_s1_v <= n_s1_v;
        end
        if (cp) begin
            r_s1_base <= pix_word;
            r_s1_cov <= cov && addr_ok;
            r_s1_fe <= last_col && last_row;
        end
    end

    // store read data arrives with the staged pixel
    assign o_job = '{base: r_s1_base, ovl: rdata, covered: r_s1_cov, frame_end: r_s1_fe};
endmodule
`default_nettype wire

// ===== design/aoac_fifo.sv =====
// short job queue between front and back ends
`default_nettype none
module aoac_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire aoac_pkg::t_job i_job,
    output      logic           o_full,
    input  wire logic           i_pop,
    output      logic           o_empty,
    output      aoac_pkg::t_job o_job
);
    localparam int D = aoac_pkg::QUEUE_DEPTH;
    localparam int PTW = $clog2(D);

    aoac_pkg::t_job r_mem [D];
    logic [PTW-1:0] r_wp, r_rp;
    logic [PTW:0]   r_cnt;

    assign o_full = r_cnt == (PTW+1)'(D);
    assign o_empty = r_cnt == '0;
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= PTW'(r_wp + 1'b1);
            end
            if (i_pop) begin
                r_rp <= PTW'(r_rp + 1'b1);
            end
            r_cnt <= (PTW+1)'(r_cnt + i_push - i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule
`default_nettype wire

// ===== design/aoac_back.sv =====
// back end: blend sequencer with one shared restoring divider and output register
`default_nettype none
module aoac_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [7:0]     i_opacity,
    input  wire logic           i_empty,
    input  wire aoac_pkg::t_job i_job,
    output      logic           o_pop,
    aoac_res_if.source          o_res
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_A    = 3'd1;
    localparam logic [2:0] ST_REST = 3'd2;
    localparam logic [2:0] ST_N    = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_LOAD = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    logic [2:0]  r_st;
    aoac_pkg::t_job r_job;
    logic [15:0] r_a;
    logic [23:0] r_rest, r_n, r_p0;
    logic [31:0] r_p1;
    logic [34:0] r_rem, r_den;
    logic [8:0]  r_q;
    logic [3:0]  r_cnt;
    logic [1:0]  r_ch;
    logic [7:0]  r_res [4];
    logic        r_ovalid;
    aoac_pkg::t_out_word r_odata;

    logic        out_free, ge;
    logic [8:0]  q_new;
    logic [7:0]  sc, dc;
    logic [33:0] m;
    logic [34:0] num, den;

    assign out_free = !r_ovalid || o_res.ready;
    assign o_pop = (r_st == ST_IDLE) && !i_empty;
    assign o_res.valid = r_ovalid;
    assign o_res.data = r_odata;

    always_comb begin
        ge = r_rem >= r_den;
        q_new = {r_q[7:0], ge};
        sc = r_job.ovl[8*r_ch +: 8];
        dc = r_job.base[8*r_ch +: 8];
        m = 34'({r_p0, 8'h00}) - 34'(r_p0) + 34'(r_p1);
        if (r_ch == CH_ALPHA) begin
            num = 35'({r_n, 1'b0}) + 35'(aoac_pkg::ALPHA_FULL);
            den = 35'(2 * aoac_pkg::ALPHA_FULL);
        end else begin
            num = 35'({m, 1'b0}) + 35'(r_n);
            den = 35'({r_n, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_st == ST_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_st <= i_job.covered ? ST_A : ST_OUT;
                    end
                end
                ST_A:    r_st <= ST_REST;
                ST_REST: r_st <= (r_a == '0) ? ST_OUT : ST_N;
                ST_N:    r_st <= ST_MUL;
                ST_MUL:  r_st <= ST_LOAD;
                ST_LOAD: r_st <= ST_DIV;
                ST_DIV: begin
                    if (r_cnt == '0) begin
                        r_st <= (r_ch == CH_ALPHA) ? ST_OUT : ST_MUL;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end

        case (r_st)
            ST_IDLE: begin
                r_job <= i_job;
                r_ch <= '0;
                for (int k = 0; k < 4; k++) begin
                    r_res[k] <= i_job.base[8*k +: 8];
                end
            end
            ST_A: r_a <= 16'(r_job.ovl[31:24]) * 16'(i_opacity);
            ST_REST: r_rest <= 24'(r_job.base[31:24]) * 24'(24'(aoac_pkg::ALPHA_FULL) - 24'(r_a));
            ST_N: r_n <= 24'({r_a, 8'h00}) - 24'(r_a) + r_rest;
            ST_MUL: begin
                r_p0 <= 24'(sc) * 24'(r_a);
                r_p1 <= 32'(dc) * 32'(r_rest);
            end
            ST_LOAD: begin
                r_rem <= num;
                r_den <= den << 8;
                r_q <= '0;
                r_cnt <= 4'd8;
            end
            ST_DIV: begin
                if (ge) begin
                    r_rem <= r_rem - r_den;
                end
                r_den <= r_den >> 1;
                r_q <= q_new;
                r_cnt <= 4'(r_cnt - 1'b1);
                if (r_cnt == '0) begin
                    r_res[r_ch] <= q_new[8] ? 8'hFF : q_new[7:0];
                    r_ch <= 2'(r_ch + 1'b1);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_odata <= '{out_red: r_res[0], out_green: r_res[1],
                                 out_blue: r_res[2], out_alpha: r_res[3],
                                 frame_end: r_job.frame_end};
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== design/anchored_overlay_alpha_composite.sv =====
// top level: configuration registers, front end, job queue and blend back end
`default_nettype none
// Overlay compositor. Load words (cmd 0) each write one overlay pixel into the
// store. Composite words (cmd 1) are placed against the anchored overlay in
// the front end, which takes one word per cycle while the four-entry job queue
// has room. The back end produces one result word per composite word: a pixel
// outside the overlay, or with zero effective alpha, skips the divider; a
// blended pixel runs the single restoring divider, which works 9 quotient bits
// per channel over four channels. Configuration must be written by the user
// through the plain write port while the block is idle; it is not enforced.
module anchored_overlay_alpha_composite #(
    parameter int OVERLAY_DEPTH = aoac_pkg::DEF_OVERLAY_DEPTH,
    parameter int MAX_DIMENSION = aoac_pkg::DEF_MAX_DIMENSION
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [aoac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [aoac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    aoac_pix_if.sink                            i_pix,
    aoac_res_if.source                          o_res
);
    aoac_pkg::t_place_cfg r_cfg;
    logic [7:0]     r_opacity;
    logic           push, full, pop, empty;
    aoac_pkg::t_job push_job, pop_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_width <= 13'd640;
            r_cfg.base_height <= 13'd480;
            r_cfg.overlay_width <= 7'd64;
            r_cfg.overlay_height <= 7'd64;
            r_cfg.anchor_position <= 4'd0;
            r_cfg.edge_margin <= 12'd0;
            r_opacity <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                aoac_pkg::CFG_BASE_WIDTH:     r_cfg.base_width <= i_cfg_data;
                aoac_pkg::CFG_BASE_HEIGHT:    r_cfg.base_height <= i_cfg_data;
                aoac_pkg::CFG_OVERLAY_WIDTH:  r_cfg.overlay_width <= i_cfg_data[6:0];
                aoac_pkg::CFG_OVERLAY_HEIGHT: r_cfg.overlay_height <= i_cfg_data[6:0];
                aoac_pkg::CFG_ANCHOR:         r_cfg.anchor_position <= i_cfg_data[3:0];
                aoac_pkg::CFG_MARGIN:         r_cfg.edge_margin <= i_cfg_data[11:0];
                aoac_pkg::CFG_OPACITY:        r_opacity <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    aoac_front #(.OVERLAY_DEPTH(OVERLAY_DEPTH), .MAX_DIMENSION(MAX_DIMENSION)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_pix   (i_pix),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    aoac_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (pop_job)
    );

    aoac_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_opacity (r_opacity),
        .i_empty   (empty),
        .i_job     (pop_job),
        .o_pop     (pop),
        .o_res     (o_res)
    );
endmodule
`default_nettype wire
